### rtl/cdta_pkg.sv
// Shared types, constants and calendar functions of the calendar date-time adder.
// Used by cdta_div and calendar_datetime_adder; depends on nothing else.
package cdta_pkg;

	localparam int unsigned AmountW   = 32;
	localparam int unsigned DivisorW  = 17;
	localparam int unsigned QuoW      = 16;
	localparam int unsigned RecipW    = 26;
	localparam int unsigned JdW       = 24;

	localparam logic [JdW-1:0] JdOffset = 24'd1721060;
	localparam logic [JdW-1:0] JdLow    = 24'd1721425;
	localparam logic [JdW-1:0] JdHigh   = 24'd2843085;
	localparam logic [31:0] SecLimit    = 32'h7fff_ffff - 32'd61;
	localparam logic [31:0] DayLimit    = 32'd3659634;
	localparam logic [13:0] FirstBadYear = 14'd1582;
	localparam logic [13:0] MaxYear     = 14'd9999;

	localparam logic [DivisorW-1:0] SecPerDay  = 17'd86400;
	localparam logic [DivisorW-1:0] SecPerHour = 17'd3600;
	localparam logic [DivisorW-1:0] SecPerMin  = 17'd60;
	localparam logic [DivisorW-1:0] DaysYearEst = 17'd366;
	localparam logic [DivisorW-1:0] DaysMonthEst = 17'd31;

	// Rounded-up reciprocals of the odd parts of the divisors above:
	// 675 scaled by 2^35, 225 by 2^21, 15 by 2^14, 183 by 2^28 and 31 by 2^14.
	// Each is exact over the operand range that reaches it.
	localparam logic [RecipW-1:0] RecipDay   = 26'd50903317;
	localparam logic [RecipW-1:0] RecipHour  = 26'd9321;
	localparam logic [RecipW-1:0] RecipMin   = 26'd1093;
	localparam logic [RecipW-1:0] RecipYear  = 26'd1466861;
	localparam logic [RecipW-1:0] RecipMonth = 26'd529;

	typedef enum logic [2:0] {
		DIV_DAY,
		DIV_HOUR,
		DIV_MIN,
		DIV_YEAR,
		DIV_MONTH
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SEC_SUM,
		ST_DAY_GO,
		ST_DAY_WT,
		ST_HR_GO,
		ST_HR_WT,
		ST_MN_GO,
		ST_MN_WT,
		ST_JD_IN,
		ST_RANGE,
		ST_YDIV_WT,
		ST_YJD,
		ST_YCMP,
		ST_MDIV_WT,
		ST_MJD,
		ST_MCMP,
		ST_FIN,
		ST_OUT
	} state_t;

	// Quotient by 100 through a reciprocal; exact for years up to 9999.
	function automatic logic [6:0] div100(input logic [13:0] y);
		logic [26:0] prod;
		begin
			prod = 27'(y) * 27'd5243;
			div100 = prod[25:19];
		end
	endfunction

	function automatic logic is_leap(input logic [13:0] y);
		logic [6:0] q;
		logic [13:0] r;
		begin
			q = div100(y);
			r = y - 14'(q) * 14'd100;
			is_leap = (y[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
		end
	endfunction

	function automatic logic [8:0] year_len(input logic [13:0] y);
		year_len = is_leap(y) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic [13:0] y, input logic [3:0] m);
		begin
			case (m)
				4'd2: month_len = is_leap(y) ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
				default: month_len = 5'd31;
			endcase
		end
	endfunction

	// Day number at noon of a Gregorian date.
	function automatic logic [JdW-1:0] jdn(input logic [13:0] y, input logic [3:0] m,
			input logic [4:0] d);
		logic [13:0] ym;
		logic [6:0] q;
		logic [8:0] sub;
		logic [2:0] corr;
		logic early;
		begin
			early = (m < 4'd3);
			if (early) begin
				// Year zero would step to minus one, whose quarter and century terms are zero.
				ym = (y == 14'd0) ? 14'd0 : y - 14'd1;
			end else begin
				ym = y;
			end
			q = div100(ym);
			sub = 9'((10'(q) + 10'd1) * 10'd3 >> 2);
			case (m)
				4'd3, 4'd4: corr = 3'd3;
				4'd5, 4'd6: corr = 3'd4;
				4'd7, 4'd8, 4'd9: corr = 3'd5;
				4'd10, 4'd11: corr = 3'd6;
				4'd12: corr = 3'd7;
				default: corr = 3'd0;
			endcase
			jdn = JdW'(y) * JdW'(365) + JdW'(m - 4'd1) * JdW'(31) + JdW'(d) + JdOffset
				+ JdW'(ym >> 2) - JdW'(sub) - JdW'(corr);
		end
	endfunction

endpackage

### rtl/cdta_div.sv
// Divider by one of a few constants: multiplies by a rounded-up reciprocal, then
// forms the remainder from the registered quotient. Depends on cdta_pkg.
module cdta_div (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  cdta_pkg::div_sel_t sel,
	input  logic [cdta_pkg::AmountW-1:0] dividend,
	output logic done,
	output logic [cdta_pkg::QuoW-1:0] quotient,
	output logic [cdta_pkg::DivisorW-1:0] remainder
);

	logic ph1_q;
	logic ph2_q;
	logic done_q;
	cdta_pkg::div_sel_t sel_q;
	logic [cdta_pkg::AmountW-1:0] dvd_q;
	logic [cdta_pkg::QuoW-1:0] quo_q;
	logic [cdta_pkg::DivisorW-1:0] rem_q;
	logic [24:0] xs;
	logic [cdta_pkg::RecipW-1:0] recip;
	logic [50:0] prod;
	logic [cdta_pkg::QuoW-1:0] quo_val;
	logic [cdta_pkg::DivisorW-1:0] dsr;
	logic [cdta_pkg::AmountW-1:0] back;

	// The power-of-two factor of each divisor is shifted off first, so the
	// multiplier only sees the odd part.
	always_comb begin
		case (sel_q)
			cdta_pkg::DIV_DAY: begin
				xs = 25'(dvd_q >> 7);
				recip = cdta_pkg::RecipDay;
				dsr = cdta_pkg::SecPerDay;
			end
			cdta_pkg::DIV_HOUR: begin
				xs = 25'(dvd_q >> 4);
				recip = cdta_pkg::RecipHour;
				dsr = cdta_pkg::SecPerHour;
			end
			cdta_pkg::DIV_MIN: begin
				xs = 25'(dvd_q >> 2);
				recip = cdta_pkg::RecipMin;
				dsr = cdta_pkg::SecPerMin;
			end
			cdta_pkg::DIV_YEAR: begin
				xs = 25'(dvd_q >> 1);
				recip = cdta_pkg::RecipYear;
				dsr = cdta_pkg::DaysYearEst;
			end
			default: begin
				xs = 25'(dvd_q);
				recip = cdta_pkg::RecipMonth;
				dsr = cdta_pkg::DaysMonthEst;
			end
		endcase
		prod = 51'(xs) * 51'(recip);
		case (sel_q)
			cdta_pkg::DIV_DAY: quo_val = cdta_pkg::QuoW'(prod >> 35);
			cdta_pkg::DIV_HOUR: quo_val = cdta_pkg::QuoW'(prod >> 21);
			cdta_pkg::DIV_MIN: quo_val = cdta_pkg::QuoW'(prod >> 14);
			cdta_pkg::DIV_YEAR: quo_val = cdta_pkg::QuoW'(prod >> 28);
			default: quo_val = cdta_pkg::QuoW'(prod >> 14);
		endcase
		back = dvd_q - cdta_pkg::AmountW'(quo_q) * cdta_pkg::AmountW'(dsr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph1_q <= 1'b0;
			ph2_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ph1_q <= go;
			ph2_q <= ph1_q;
			done_q <= ph2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			sel_q <= sel;
		end
		if (ph1_q) quo_q <= quo_val;
		if (ph2_q) rem_q <= cdta_pkg::DivisorW'(back);
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !ph1_q && !ph2_q)
		else $error("divider started while running");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ph2_q))
		else $error("divider done without a finished run");
	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> remainder < dsr)
		else $error("divider remainder not below divisor");

endmodule

### rtl/calendar_datetime_adder.sv
// Calendar date-time adder: adds seconds or days to a Gregorian date-time.
// Depends on cdta_pkg and cdta_div.
//
// Usage: present func, amount and the in_* fields and raise start while busy
// is low; that beat is taken at the clock edge. busy then stays high until the
// result has been shown. The result appears for exactly one cycle with done
// high; status 1 marks an invalid input or a date out of range, and then all
// other result fields are zero. The receiver cannot hold a result off.
// An invalid input shows its result in the cycle right after the accepting
// edge. A day number outside the window is reported after the range check
// in both modes. Every division is by a constant and goes through one shared
// reciprocal divider: whole days, hours and minutes in seconds mode, then the
// year and month estimates. Each step of the year search passes ST_YJD and
// ST_YCMP, each step of the month search ST_MJD and ST_MCMP; each step is one
// pass through the day-number unit. One item is in work at a time and the
// next beat can be taken once the result has been shown.
// Reset returns the sequencer to idle; no result is pending after it.
module calendar_datetime_adder (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic func,
	input  logic signed [31:0] amount,
	input  logic [13:0] in_year,
	input  logic [6:0] in_month,
	input  logic [6:0] in_day,
	input  logic [6:0] in_hour,
	input  logic [6:0] in_minute,
	input  logic [6:0] in_second,
	output logic done,
	output logic status,
	output logic [13:0] out_year,
	output logic [3:0] out_month,
	output logic [4:0] out_day,
	output logic [4:0] out_hour,
	output logic [5:0] out_minute,
	output logic [5:0] out_second
);

	cdta_pkg::state_t state_q, state_d;

	logic ok_q;
	logic func_q;
	logic [31:0] tot_q;
	logic [21:0] nd_q;
	logic [13:0] iy_q;
	logic [3:0] im_q;
	logic [4:0] id_q;
	logic [4:0] hour_q;
	logic [5:0] min_q;
	logic [5:0] sec_q;
	logic [cdta_pkg::JdW-1:0] n_q;
	logic [cdta_pkg::JdW-1:0] jd_q;
	logic [13:0] y_q;
	logic [3:0] m_q;
	logic [5:0] d_q;

	logic bad_in;
	logic take;
	logic in_window;
	logic [cdta_pkg::JdW-1:0] jd_val;
	logic signed [cdta_pkg::JdW:0] delta;
	logic [4:0] mlen;

	logic div_go;
	logic [31:0] div_dvd;
	cdta_pkg::div_sel_t div_sel;
	logic div_done;
	logic [cdta_pkg::QuoW-1:0] div_quo;
	logic [cdta_pkg::DivisorW-1:0] div_rem;

	assign take = start && !busy;

	always_comb begin
		bad_in = amount[31]
			|| (!func && $unsigned(amount) >= cdta_pkg::SecLimit)
			|| (func && $unsigned(amount) >= cdta_pkg::DayLimit)
			|| (in_year <= cdta_pkg::FirstBadYear) || (in_year > cdta_pkg::MaxYear)
			|| (in_month < 7'd1) || (in_month > 7'd12)
			|| (in_day < 7'd1) || (in_day > 7'd31)
			|| (in_hour > 7'd23) || (in_minute > 7'd59) || (in_second > 7'd60);
	end

	// Day-number unit, shared by the input date and both searches.
	always_comb begin
		case (state_q)
			cdta_pkg::ST_JD_IN: jd_val = cdta_pkg::jdn(iy_q, im_q, id_q);
			cdta_pkg::ST_YJD: jd_val = cdta_pkg::jdn(y_q, 4'd1, 5'd1);
			default: jd_val = cdta_pkg::jdn(y_q, m_q, 5'd1);
		endcase
		delta = $signed({1'b0, n_q}) - $signed({1'b0, jd_q});
		mlen = cdta_pkg::month_len(y_q, m_q);
		in_window = (n_q >= cdta_pkg::JdLow) && (n_q <= cdta_pkg::JdHigh);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cdta_pkg::ST_IDLE: begin
				if (take) begin
					if (bad_in) state_d = cdta_pkg::ST_OUT;
					else if (!func) state_d = cdta_pkg::ST_SEC_SUM;
					else state_d = cdta_pkg::ST_JD_IN;
				end
			end
			cdta_pkg::ST_SEC_SUM: state_d = cdta_pkg::ST_DAY_GO;
			cdta_pkg::ST_DAY_GO: state_d = cdta_pkg::ST_DAY_WT;
			cdta_pkg::ST_DAY_WT: if (div_done) state_d = cdta_pkg::ST_HR_GO;
			cdta_pkg::ST_HR_GO: state_d = cdta_pkg::ST_HR_WT;
			cdta_pkg::ST_HR_WT: if (div_done) state_d = cdta_pkg::ST_MN_GO;
			cdta_pkg::ST_MN_GO: state_d = cdta_pkg::ST_MN_WT;
			cdta_pkg::ST_MN_WT: if (div_done) state_d = cdta_pkg::ST_JD_IN;
			cdta_pkg::ST_JD_IN: state_d = cdta_pkg::ST_RANGE;
			cdta_pkg::ST_RANGE: state_d = in_window ? cdta_pkg::ST_YDIV_WT : cdta_pkg::ST_OUT;
			cdta_pkg::ST_YDIV_WT: if (div_done) state_d = cdta_pkg::ST_YJD;
			cdta_pkg::ST_YJD: state_d = cdta_pkg::ST_YCMP;
			cdta_pkg::ST_YCMP: begin
				if (delta > $signed({16'd0, cdta_pkg::year_len(y_q)})) state_d = cdta_pkg::ST_YJD;
				else state_d = cdta_pkg::ST_MDIV_WT;
			end
			cdta_pkg::ST_MDIV_WT: if (div_done) state_d = cdta_pkg::ST_MJD;
			cdta_pkg::ST_MJD: state_d = cdta_pkg::ST_MCMP;
			cdta_pkg::ST_MCMP: begin
				if (delta > $signed({20'd0, mlen})) state_d = cdta_pkg::ST_MJD;
				else state_d = cdta_pkg::ST_FIN;
			end
			cdta_pkg::ST_FIN: state_d = cdta_pkg::ST_OUT;
			cdta_pkg::ST_OUT: state_d = cdta_pkg::ST_IDLE;
			default: state_d = cdta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != cdta_pkg::ST_IDLE);
		done = (state_q == cdta_pkg::ST_OUT);
		div_go = 1'b0;
		div_dvd = tot_q;
		div_sel = cdta_pkg::DIV_DAY;
		case (state_q)
			cdta_pkg::ST_DAY_GO: div_go = 1'b1;
			cdta_pkg::ST_HR_GO: begin
				div_go = 1'b1;
				div_sel = cdta_pkg::DIV_HOUR;
			end
			cdta_pkg::ST_MN_GO: begin
				div_go = 1'b1;
				div_sel = cdta_pkg::DIV_MIN;
			end
			cdta_pkg::ST_RANGE: begin
				div_go = in_window;
				div_dvd = 32'(n_q - cdta_pkg::JdOffset);
				div_sel = cdta_pkg::DIV_YEAR;
			end
			cdta_pkg::ST_YCMP: begin
				div_go = !(delta > $signed({16'd0, cdta_pkg::year_len(y_q)}));
				div_dvd = 32'(delta[8:0]);
				div_sel = cdta_pkg::DIV_MONTH;
			end
			default: div_go = 1'b0;
		endcase
	end

	cdta_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.sel(div_sel),
		.dividend(div_dvd),
		.done(div_done),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdta_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cdta_pkg::ST_IDLE: begin
				if (take) begin
					ok_q <= !bad_in;
					func_q <= func;
					iy_q <= in_year;
					im_q <= in_month[3:0];
					id_q <= in_day[4:0];
					hour_q <= in_hour[4:0];
					min_q <= in_minute[5:0];
					sec_q <= in_second[5:0];
					nd_q <= amount[21:0];
					tot_q <= $unsigned(amount);
				end
			end
			cdta_pkg::ST_SEC_SUM: begin
				// Seconds, minutes and hours fold into one count before the carries.
				tot_q <= tot_q + 32'(sec_q) + 32'(min_q) * 32'd60
					+ 32'(hour_q) * 32'd3600;
			end
			cdta_pkg::ST_DAY_WT: begin
				if (div_done) begin
					nd_q <= 22'(div_quo);
					tot_q <= 32'(div_rem);
				end
			end
			cdta_pkg::ST_HR_WT: begin
				if (div_done) begin
					hour_q <= div_quo[4:0];
					tot_q <= 32'(div_rem);
				end
			end
			cdta_pkg::ST_MN_WT: begin
				if (div_done) begin
					min_q <= div_quo[5:0];
					sec_q <= div_rem[5:0];
				end
			end
			cdta_pkg::ST_JD_IN: n_q <= jd_val + cdta_pkg::JdW'(nd_q);
			cdta_pkg::ST_RANGE: if (!in_window) ok_q <= 1'b0;
			cdta_pkg::ST_YDIV_WT: if (div_done) y_q <= div_quo[13:0];
			cdta_pkg::ST_YJD, cdta_pkg::ST_MJD: jd_q <= jd_val;
			cdta_pkg::ST_YCMP: begin
				if (delta > $signed({16'd0, cdta_pkg::year_len(y_q)})) y_q <= y_q + 14'd1;
			end
			cdta_pkg::ST_MDIV_WT: if (div_done) m_q <= div_quo[3:0] + 4'd1;
			cdta_pkg::ST_MCMP: begin
				if (delta > $signed({20'd0, mlen})) begin
					if (m_q == 4'd12) begin
						m_q <= 4'd1;
						y_q <= y_q + 14'd1;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end else begin
					// The day can reach 32 here, so it keeps a sixth bit until the fix-up.
					d_q <= delta[5:0] + 6'd1;
				end
			end
			cdta_pkg::ST_FIN: begin
				// A day one past the month end moves to the first of the next month.
				if (d_q > {1'b0, mlen}) begin
					d_q <= 6'd1;
					if (m_q == 4'd12) begin
						m_q <= 4'd1;
						y_q <= y_q + 14'd1;
						if (y_q + 14'd1 > cdta_pkg::MaxYear) ok_q <= 1'b0;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end else if (y_q > cdta_pkg::MaxYear) begin
					ok_q <= 1'b0;
				end
			end
			default: ok_q <= ok_q;
		endcase
	end

	always_comb begin
		status = !ok_q;
		out_year = ok_q ? y_q : 14'd0;
		out_month = ok_q ? m_q : 4'd0;
		out_day = ok_q ? d_q[4:0] : 5'd0;
		out_hour = ok_q ? hour_q : 5'd0;
		out_minute = ok_q ? min_q : 6'd0;
		out_second = ok_q ? sec_q : 6'd0;
	end

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n) take |=> busy)
		else $error("accepted beat did not raise busy");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (out_year == 14'd0) && (out_month == 4'd0))
		else $error("error result carries a date");
	a_ok_month: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !status) |-> (out_month >= 4'd1) && (out_month <= 4'd12)
			&& (out_day >= 5'd1))
		else $error("valid result with month or day out of range");
	a_mode_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !$past(take) && !done) |-> $stable(func_q))
		else $error("mode changed during an item");

endmodule

### bench/cdta_checker.sv
// Checker for the calendar date-time adder: watches accepted beats and results.
// Predicts each result with its own calendar arithmetic; depends on nothing else.
`timescale 1ns / 1ps

module cdta_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic func,
	input  logic signed [31:0] amount,
	input  logic [13:0] in_year,
	input  logic [6:0] in_month,
	input  logic [6:0] in_day,
	input  logic [6:0] in_hour,
	input  logic [6:0] in_minute,
	input  logic [6:0] in_second,
	input  logic done,
	input  logic status,
	input  logic [13:0] out_year,
	input  logic [3:0] out_month,
	input  logic [4:0] out_day,
	input  logic [4:0] out_hour,
	input  logic [5:0] out_minute,
	input  logic [5:0] out_second,
	output int failures,
	output int pending
);

	typedef struct packed {
		logic status;
		logic [13:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} datetime_t;

	datetime_t sums_due[$];

	function automatic bit leap_year(longint y);
		if (y % 400 == 0) return 1;
		if (y % 100 == 0) return 0;
		return (y % 4) == 0;
	endfunction

	function automatic longint days_in_month(longint y, longint m);
		if (m == 2) return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
		return 31;
	endfunction

	function automatic longint noon_day_number(longint y, longint m, longint d);
		longint n;
		n = 365 * y + 31 * (m - 1) + d + 1721060;
		if (m < 3) y--;
		else n -= (4 * m + 23) / 10;
		n += y / 4 - ((y / 100 + 1) * 3) / 4;
		return n;
	endfunction

	function automatic datetime_t add_to_datetime(logic f, logic signed [31:0] amt,
			longint y, longint mo, longint d, longint h, longint mi, longint s);
		datetime_t r;
		longint a, ndays, n, delta, ry, rm, rd;
		bit ok;
		a = amt;
		ok = 1;
		r = '0;
		if (a < 0) ok = 0;
		if (f == 0 && a >= 64'h7fffffff - 61) ok = 0;
		if (f == 1 && a >= 9999 * 366) ok = 0;
		if (y <= 1582 || y > 9999) ok = 0;
		if (mo < 1 || mo > 12 || d < 1 || d > 31) ok = 0;
		if (h > 23 || mi > 59 || s > 60) ok = 0;
		if (ok) begin
			if (f == 0) begin
				s += a;
				mi += s / 60;
				s %= 60;
				h += mi / 60;
				mi %= 60;
				ndays = h / 24;
				h %= 24;
			end else begin
				ndays = a;
			end
			n = noon_day_number(y, mo, d) + ndays;
			if (n < 1721425 || n > 2843085) begin
				ok = 0;
			end else begin
				ry = (n - 1721060) / 366;
				delta = n - noon_day_number(ry, 1, 1);
				while (delta > (leap_year(ry) ? 366 : 365)) begin
					ry++;
					delta = n - noon_day_number(ry, 1, 1);
				end
				rm = delta / 31 + 1;
				delta = n - noon_day_number(ry, rm, 1);
				while (delta > days_in_month(ry, rm)) begin
					rm++;
					if (rm > 12) begin
						rm = 1;
						ry++;
					end
					delta = n - noon_day_number(ry, rm, 1);
				end
				rd = delta + 1;
				if (rd > days_in_month(ry, rm)) begin
					rd = 1;
					rm++;
				end
				if (rm > 12) begin
					rm = 1;
					ry++;
				end
				if (ry > 9999 || rm < 1 || rm > 12 || rd < 1 || rd > 31) ok = 0;
			end
		end
		if (!ok) begin
			r.status = 1'b1;
			return r;
		end
		r.year = 14'(ry);
		r.month = 4'(rm);
		r.day = 5'(rd);
		r.hour = 5'(h);
		r.minute = 6'(mi);
		r.second = 6'(s);
		return r;
	endfunction

	initial failures = 0;
	initial pending = 0;

	always @(posedge clk) begin
		datetime_t want;
		if (arst_n) begin
			if (start && !busy)
				sums_due.push_back(add_to_datetime(func, amount, in_year, in_month, in_day,
					in_hour, in_minute, in_second));
			if (done) begin
				if (sums_due.size() == 0) begin
					$error("result beat with no expectation");
					failures++;
				end else begin
					want = sums_due.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d actual %0d", want.status, status);
						failures++;
					end
					if (out_year !== want.year) begin
						$error("out_year: expected %0d actual %0d", want.year, out_year);
						failures++;
					end
					if (out_month !== want.month) begin
						$error("out_month: expected %0d actual %0d", want.month, out_month);
						failures++;
					end
					if (out_day !== want.day) begin
						$error("out_day: expected %0d actual %0d", want.day, out_day);
						failures++;
					end
					if (out_hour !== want.hour) begin
						$error("out_hour: expected %0d actual %0d", want.hour, out_hour);
						failures++;
					end
					if (out_minute !== want.minute) begin
						$error("out_minute: expected %0d actual %0d", want.minute, out_minute);
						failures++;
					end
					if (out_second !== want.second) begin
						$error("out_second: expected %0d actual %0d", want.second, out_second);
						failures++;
					end
				end
			end
		end
		pending = sums_due.size();
	end

endmodule

### bench/tb.sv
// Top of the calendar date-time adder bench: clock, reset, stimulus and verdict.
// Depends on calendar_datetime_adder and cdta_checker.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned RandomBeats = 630;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic func;
	logic signed [31:0] amount;
	logic [13:0] in_year;
	logic [6:0] in_month, in_day, in_hour, in_minute, in_second;
	logic done, status;
	logic [13:0] out_year;
	logic [3:0] out_month;
	logic [4:0] out_day, out_hour;
	logic [5:0] out_minute, out_second;
	int failures, pending;
	int unsigned cycles;

	calendar_datetime_adder DUT (.*);
	cdta_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Presents one beat and holds it until the block takes it.
	task automatic send_beat(logic f, logic signed [31:0] a, logic [13:0] y, logic [6:0] mo,
			logic [6:0] d, logic [6:0] h, logic [6:0] mi, logic [6:0] s, bit may_idle);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		amount <= a;
		in_year <= y;
		in_month <= mo;
		in_day <= d;
		in_hour <= h;
		in_minute <= mi;
		in_second <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_amount(logic f);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return f ? 32'(3659634 - $urandom_range(0, 3)) : 32'(32'h7fffffff - 61 - $urandom_range(0, 2));
			2, 3: return $urandom_range(0, 400);
			4: return f ? $urandom_range(0, 3659640) : $urandom_range(0, 32'h7fffffff);
			default: return f ? $urandom_range(0, 800000) : $urandom_range(0, 200000000);
		endcase
	endfunction

	initial begin
		logic f;
		bit noisy;
		start = 1'b0;
		func = 1'b0;
		amount = '0;
		in_year = 14'd2000;
		in_month = 7'd1;
		in_day = 7'd1;
		in_hour = '0;
		in_minute = '0;
		in_second = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: limits, leap days, rollovers and each rejection reason.
		send_beat(0, 0, 1583, 1, 1, 0, 0, 0, 0);
		send_beat(1, 0, 9999, 12, 31, 23, 59, 60, 0);
		send_beat(0, 1, 9999, 12, 31, 23, 59, 59, 0);
		send_beat(0, 32'h7fffffff - 62, 1583, 1, 1, 0, 0, 0, 0);
		send_beat(0, 32'h7fffffff - 61, 1583, 1, 1, 0, 0, 0, 0);
		send_beat(1, 3659633, 1583, 1, 1, 0, 0, 0, 0);
		send_beat(1, 3659634, 1583, 1, 1, 0, 0, 0, 0);
		send_beat(1, -1, 2000, 6, 15, 12, 0, 0, 0);
		send_beat(0, 32'h80000000, 2000, 6, 15, 12, 0, 0, 0);
		send_beat(1, 1, 1582, 12, 31, 0, 0, 0, 0);
		send_beat(1, 1, 14'h3fff, 1, 1, 0, 0, 0, 0);
		send_beat(1, 1, 2000, 0, 1, 0, 0, 0, 0);
		send_beat(1, 1, 2000, 13, 1, 0, 0, 0, 0);
		send_beat(1, 1, 2000, 1, 0, 0, 0, 0, 0);
		send_beat(1, 1, 2000, 1, 32, 0, 0, 0, 0);
		send_beat(1, 1, 2000, 1, 1, 24, 0, 0, 0);
		send_beat(1, 1, 2000, 1, 1, 0, 60, 0, 0);
		send_beat(1, 1, 2000, 1, 1, 0, 0, 61, 0);
		send_beat(1, 1, 2000, 2, 28, 0, 0, 0, 0);
		send_beat(1, 1, 1900, 2, 28, 0, 0, 0, 0);
		send_beat(1, 0, 2001, 4, 31, 0, 0, 0, 0);
		send_beat(1, 0, 2001, 2, 31, 0, 0, 0, 0);
		send_beat(0, 86400, 2004, 12, 31, 23, 59, 60, 0);
		send_beat(1, 0, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 0);

		// Mostly valid dates with random amounts; some noise; no idling at the end.
		for (int k = 0; k < RandomBeats; k++) begin
			f = $urandom_range(0, 1);
			noisy = ($urandom_range(0, 7) == 0);
			send_beat(f, pick_amount(f),
				noisy ? 14'($urandom()) : 14'($urandom_range(1583, 9999)),
				noisy ? 7'($urandom()) : 7'($urandom_range(1, 12)),
				noisy ? 7'($urandom()) : 7'($urandom_range(1, 31)),
				noisy ? 7'($urandom()) : 7'($urandom_range(0, 23)),
				noisy ? 7'($urandom()) : 7'($urandom_range(0, 59)),
				noisy ? 7'($urandom()) : 7'($urandom_range(0, 60)),
				k < RandomBeats - 80);
		end
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
